// ===== sv/bol_pkg.sv =====
`timescale 1ns / 1ps

package bol_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int SUM_W    = CNT_W + 1;
  localparam int DATA_W   = 32;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_INSERT     = 3'd4,
    OP_SEARCH     = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_BADPOS = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_WR,
    S_INS_PUT,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_RESP
  } state_t;

  localparam logic [6:0] NOT_FOUND = 7'h7F;

  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [DATA_W-1:0] wdata;
    logic [IDX_W-1:0]  raddr;
  } ram_req_t;

  // logical position -> physical slot of the circular buffer
  function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] head,
                                            input logic [CNT_W-1:0] lpos);
    logic [SUM_W-1:0] s;
    s = SUM_W'(head) + SUM_W'(lpos);
    if (s >= SUM_W'(CAPACITY)) s = s - SUM_W'(CAPACITY);
    return s[IDX_W-1:0];
  endfunction

endpackage

// ===== sv/bol_req_if.sv =====
`timescale 1ns / 1ps

interface bol_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  operation;
  logic signed [31:0] value;
  logic [6:0]  position;
  logic signed [31:0] key;

  modport source (output valid, operation, value, position, key, input ready);
  modport sink   (input valid, operation, value, position, key, output ready);
endinterface

// ===== sv/bol_rsp_if.sv =====
`timescale 1ns / 1ps

interface bol_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic signed [6:0] found_index;
  logic [6:0]  entry_count;

  modport source (output valid, status, found_index, entry_count, input ready);
  modport sink   (input valid, status, found_index, entry_count, output ready);
endinterface

// ===== sv/bounded_ordered_list_top.sv =====
`timescale 1ns / 1ps

// Bounded ordered list of up to CAPACITY signed 32-bit values, kept as a
// circular buffer in one single-port-read RAM with a head pointer and a
// count. One request is handled at a time. Push front/back, pop front/back,
// refused requests and unused codes go straight from the input transfer
// to the result state. An insert at position p moves each entry from the
// end down to p one slot back (one RAM read plus one write per entry), then
// writes the new value at p; an insert at the end is written directly. A
// search compares entries from index 0 on until a match or the last one,
// skipped on an empty list. A finished result sits in an output register,
// so the next request is taken while it waits.
module bounded_ordered_list_top (
  input logic         clk,
  input logic         rst_n,
  bol_req_if.sink     in_ch,
  bol_rsp_if.source   out_ch
);

  bol_pkg::ram_req_t          ram_req;
  logic [bol_pkg::DATA_W-1:0] ram_rdata;

  // sequencer: pointers, count, shift and search sweeps
  bol_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata)
  );

  // entry storage, contents undefined until written
  bol_ram #(
    .WIDTH (bol_pkg::DATA_W),
    .DEPTH (bol_pkg::CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

`ifndef SYNTH
  // full status only with a full list
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status == bol_pkg::ST_FULL |->
      out_ch.entry_count == 7'(bol_pkg::CAPACITY))
    else $error("full status with list not full");

  // empty status only with an empty list
  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status == bol_pkg::ST_EMPTY |-> out_ch.entry_count == 7'd0)
    else $error("empty status with entries held");

  // a hit implies ok status and index below count
  a_hit_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.found_index != bol_pkg::NOT_FOUND |->
      out_ch.status == bol_pkg::ST_OK && out_ch.found_index < out_ch.entry_count)
    else $error("bad search result");
`endif

endmodule

// ===== sv/bol_ram.sv =====
`timescale 1ns / 1ps

module bol_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/bol_ctrl.sv =====
`timescale 1ns / 1ps

module bol_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  bol_req_if.sink                       in_ch,
  bol_rsp_if.source                     out_ch,
  output bol_pkg::ram_req_t             ram_req,
  input  logic [bol_pkg::DATA_W-1:0]    ram_rdata
);

  bol_pkg::state_t state_r, state_nxt;
  logic [bol_pkg::IDX_W-1:0]  head_r, head_nxt;
  logic [bol_pkg::CNT_W-1:0]  count_r, count_nxt;
  logic [bol_pkg::CNT_W-1:0]  j_r, j_nxt;
  logic [bol_pkg::CNT_W-1:0]  pos_r, pos_nxt;
  logic [bol_pkg::DATA_W-1:0] val_r, val_nxt;
  logic [bol_pkg::DATA_W-1:0] key_r, key_nxt;
  bol_pkg::status_t           res_status_r, res_status_nxt;
  logic [6:0]                 res_found_r, res_found_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [1:0]                 out_status_r;
  logic [6:0]                 out_found_r, out_count_r;

  logic accept, full, empty, badpos, at_end, load;
  logic [bol_pkg::IDX_W-1:0] head_m1;
  bol_pkg::op_t op;

  assign op      = bol_pkg::op_t'(in_ch.operation);
  assign accept  = in_ch.valid && in_ch.ready;
  assign full    = (32'(count_r) >= 32'(bol_pkg::CAPACITY));
  assign empty   = (count_r == '0);
  assign badpos  = (32'(in_ch.position) > 32'(count_r));
  assign at_end  = (32'(in_ch.position) == 32'(count_r));
  assign head_m1 = (head_r == '0) ? bol_pkg::IDX_W'(bol_pkg::CAPACITY - 1)
                                  : head_r - 1'b1;
  assign load    = (state_r == bol_pkg::S_RESP) && (!out_valid_r || out_ch.ready);

  assign in_ch.ready        = (state_r == bol_pkg::S_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.found_index = out_found_r;
  assign out_ch.entry_count = out_count_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bol_pkg::S_IDLE: begin
        if (accept) begin
          state_nxt = bol_pkg::S_RESP;
          if (op == bol_pkg::OP_INSERT && !badpos && !full && !at_end)
            state_nxt = bol_pkg::S_INS_RD;
          if (op == bol_pkg::OP_SEARCH && !empty)
            state_nxt = bol_pkg::S_SRCH_RD;
        end
      end
      bol_pkg::S_INS_RD:  state_nxt = bol_pkg::S_INS_WR;
      bol_pkg::S_INS_WR:  state_nxt = (j_r - 1'b1 == pos_r) ? bol_pkg::S_INS_PUT
                                                           : bol_pkg::S_INS_RD;
      bol_pkg::S_INS_PUT: state_nxt = bol_pkg::S_RESP;
      bol_pkg::S_SRCH_RD: state_nxt = bol_pkg::S_SRCH_CMP;
      bol_pkg::S_SRCH_CMP: begin
        if (ram_rdata == key_r || j_r + 1'b1 == count_r) state_nxt = bol_pkg::S_RESP;
        else state_nxt = bol_pkg::S_SRCH_RD;
      end
      bol_pkg::S_RESP:    if (load) state_nxt = bol_pkg::S_IDLE;
      default:            state_nxt = bol_pkg::S_IDLE;
    endcase
  end

  // datapath and memory requests
  always_comb begin
    head_nxt       = head_r;
    count_nxt      = count_r;
    j_nxt          = j_r;
    pos_nxt        = pos_r;
    val_nxt        = val_r;
    key_nxt        = key_r;
    res_status_nxt = res_status_r;
    res_found_nxt  = res_found_r;
    ram_req.we     = 1'b0;
    ram_req.waddr  = bol_pkg::phys(head_r, count_r);
    ram_req.wdata  = in_ch.value;
    ram_req.raddr  = bol_pkg::phys(head_r, j_r);
    unique case (state_r)
      bol_pkg::S_IDLE: begin
        if (accept) begin
          res_status_nxt = bol_pkg::ST_OK;
          res_found_nxt  = bol_pkg::NOT_FOUND;
          val_nxt        = in_ch.value;
          key_nxt        = in_ch.key;
          pos_nxt        = bol_pkg::CNT_W'(in_ch.position);
          j_nxt          = count_r;
          unique case (op)
            bol_pkg::OP_PUSH_FRONT: begin
              if (full) res_status_nxt = bol_pkg::ST_FULL;
              else begin
                ram_req.we    = 1'b1;
                ram_req.waddr = head_m1;
                head_nxt      = head_m1;
                count_nxt     = count_r + 1'b1;
              end
            end
            bol_pkg::OP_PUSH_BACK: begin
              if (full) res_status_nxt = bol_pkg::ST_FULL;
              else begin
                ram_req.we = 1'b1;
                count_nxt  = count_r + 1'b1;
              end
            end
            bol_pkg::OP_POP_FRONT: begin
              if (empty) res_status_nxt = bol_pkg::ST_EMPTY;
              else begin
                head_nxt  = bol_pkg::phys(head_r, bol_pkg::CNT_W'(1));
                count_nxt = count_r - 1'b1;
              end
            end
            bol_pkg::OP_POP_BACK: begin
              if (empty) res_status_nxt = bol_pkg::ST_EMPTY;
              else count_nxt = count_r - 1'b1;
            end
            bol_pkg::OP_INSERT: begin
              if (badpos) res_status_nxt = bol_pkg::ST_BADPOS;
              else if (full) res_status_nxt = bol_pkg::ST_FULL;
              else if (at_end) begin
                ram_req.we = 1'b1;
                count_nxt  = count_r + 1'b1;
              end
            end
            bol_pkg::OP_SEARCH: j_nxt = '0;
            default: ;
          endcase
        end
      end
      bol_pkg::S_INS_RD: ram_req.raddr = bol_pkg::phys(head_r, j_r - 1'b1);
      bol_pkg::S_INS_WR: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = bol_pkg::phys(head_r, j_r);
        ram_req.wdata = ram_rdata;
        j_nxt         = j_r - 1'b1;
      end
      bol_pkg::S_INS_PUT: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = bol_pkg::phys(head_r, pos_r);
        ram_req.wdata = val_r;
        count_nxt     = count_r + 1'b1;
      end
      bol_pkg::S_SRCH_RD: ;
      bol_pkg::S_SRCH_CMP: begin
        if (ram_rdata == key_r) res_found_nxt = 7'(j_r);
        j_nxt = j_r + 1'b1;
      end
      bol_pkg::S_RESP: ;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ch.ready) out_valid_nxt = 1'b0;
    if (load) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bol_pkg::S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    j_r          <= j_nxt;
    pos_r        <= pos_nxt;
    val_r        <= val_nxt;
    key_r        <= key_nxt;
    res_status_r <= res_status_nxt;
    res_found_r  <= res_found_nxt;
    if (load) begin
      out_status_r <= res_status_r;
      out_found_r  <= res_found_r;
      out_count_r  <= 7'(count_r);
    end
  end

endmodule
